FILE: rtl/dcpv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcpv_pkg;

  // field widths fixed by the pixel and result formats
  localparam int LEVEL_W  = 8;
  localparam int COLUMN_W = 12;
  localparam int BONUS_W  = 4;
  localparam int TOTAL_W  = 24;
  localparam int INC_W    = BONUS_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // depth of the command queue and the result queue (power of two)
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_END   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_BONUS = 2'd3;

  // configuration reset values
  localparam logic [LEVEL_W-1:0]  MIN_LEVEL_RST  = 8'd125;
  localparam logic [COLUMN_W-1:0] BAND_START_RST = 12'd128;
  localparam logic [COLUMN_W-1:0] BAND_END_RST   = 12'd512;
  localparam logic [BONUS_W-1:0]  BAND_BONUS_RST = 4'd3;

  // vote codes carried from front to back
  localparam logic [1:0] VOTE_NONE  = 2'd0;
  localparam logic [1:0] VOTE_BLUE  = 2'd1;
  localparam logic [1:0] VOTE_GREEN = 2'd2;
  localparam logic [1:0] VOTE_RED   = 2'd3;

  // verdict codes
  localparam logic [1:0] VERDICT_BLUE  = 2'd0;
  localparam logic [1:0] VERDICT_GREEN = 2'd1;
  localparam logic [1:0] VERDICT_RED   = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0]  blue_level;
    logic [LEVEL_W-1:0]  green_level;
    logic [LEVEL_W-1:0]  red_level;
    logic [COLUMN_W-1:0] column_index;
    logic                frame_end;
  } pixel_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic [TOTAL_W-1:0] blue_total;
    logic [TOTAL_W-1:0] green_total;
    logic [TOTAL_W-1:0] red_total;
  } result_t;

  typedef struct packed {
    logic [1:0]       vote;
    logic [INC_W-1:0] inc;
    logic             last;
  } vote_t;

endpackage

`default_nettype wire

FILE: rtl/dcpv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dcpv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CntW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

FILE: rtl/dcpv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dcpv_front import dcpv_pkg::*; #(
  parameter int COLUMN_WIDTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire pixel_t                pix,
  output vote_t                      vote_cmd
);

  localparam logic [COLUMN_W-1:0] ColMask = (COLUMN_WIDTH >= COLUMN_W) ? {COLUMN_W{1'b1}} :
    COLUMN_W'((32'd1 << COLUMN_WIDTH) - 32'd1);

  logic [LEVEL_W-1:0]  min_level_r;
  logic [COLUMN_W-1:0] band_start_r;
  logic [COLUMN_W-1:0] band_end_r;
  logic [BONUS_W-1:0]  band_bonus_r;

  logic [COLUMN_W-1:0] col;
  logic                in_band;
  logic                blue_win, green_win, red_win;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r  <= MIN_LEVEL_RST;
      band_start_r <= BAND_START_RST;
      band_end_r   <= BAND_END_RST;
      band_bonus_r <= BAND_BONUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_LEVEL:  min_level_r  <= cfg_data[LEVEL_W-1:0];
        REG_BAND_START: band_start_r <= cfg_data[COLUMN_W-1:0];
        REG_BAND_END:   band_end_r   <= cfg_data[COLUMN_W-1:0];
        REG_BAND_BONUS: band_bonus_r <= cfg_data[BONUS_W-1:0];
        default: ;
      endcase
    end
  end

  // a dominates b and c: 2a > 3b, 2a > 3c and a above the level threshold
  function automatic logic dominates(input logic [LEVEL_W-1:0] a,
                                     input logic [LEVEL_W-1:0] b,
                                     input logic [LEVEL_W-1:0] c,
                                     input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W+1:0] a2, b3, c3;
    a2 = {1'b0, a, 1'b0};
    b3 = {1'b0, b, 1'b0} + {2'b00, b};
    c3 = {1'b0, c, 1'b0} + {2'b00, c};
    return (a2 > b3) && (a2 > c3) && (a > lvl);
  endfunction

  // column band test
  assign col     = pix.column_index & ColMask;
  assign in_band = (col > band_start_r) && (col < band_end_r);

  // channel tests, blue first
  assign blue_win  = dominates(pix.blue_level, pix.green_level, pix.red_level, min_level_r);
  assign green_win = dominates(pix.green_level, pix.blue_level, pix.red_level, min_level_r);
  assign red_win   = dominates(pix.red_level, pix.blue_level, pix.green_level, min_level_r);

  // build the command for the back end
  always_comb begin
    vote_cmd.last = pix.frame_end;
    vote_cmd.inc  = in_band ? INC_W'(band_bonus_r) + INC_W'(1) : INC_W'(1);
    if (blue_win) begin
      vote_cmd.vote = VOTE_BLUE;
    end else if (green_win) begin
      vote_cmd.vote = VOTE_GREEN;
    end else if (red_win) begin
      vote_cmd.vote = VOTE_RED;
    end else begin
      vote_cmd.vote = VOTE_NONE;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dcpv_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dcpv_back import dcpv_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire vote_t cmd,
  input  wire logic  cmd_empty,
  output logic       cmd_pop,
  input  wire logic  res_full,
  output logic       res_push,
  output result_t    res
);

  localparam int WideW = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

  logic [COUNT_WIDTH-1:0] blue_acc_r, blue_acc_nxt;
  logic [COUNT_WIDTH-1:0] green_acc_r, green_acc_nxt;
  logic [COUNT_WIDTH-1:0] red_acc_r, red_acc_nxt;
  logic [COUNT_WIDTH-1:0] blue_upd, green_upd, red_upd;
  logic [WideW-1:0]       blue_wide, green_wide, red_wide;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] acc,
                                                     input logic [INC_W-1:0] inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, acc} + (COUNT_WIDTH+1)'(inc);
    return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  endfunction

  // a closing command waits for room in the result queue
  assign cmd_pop  = !cmd_empty && (!cmd.last || !res_full);
  assign res_push = cmd_pop && cmd.last;

  // counters after this pixel's vote
  assign blue_upd  = (cmd.vote == VOTE_BLUE) ? sat_add(blue_acc_r, cmd.inc) : blue_acc_r;
  assign green_upd = (cmd.vote == VOTE_GREEN) ? sat_add(green_acc_r, cmd.inc) : green_acc_r;
  assign red_upd   = (cmd.vote == VOTE_RED) ? sat_add(red_acc_r, cmd.inc) : red_acc_r;

  // result formed from the updated counters
  assign blue_wide  = WideW'(blue_upd);
  assign green_wide = WideW'(green_upd);
  assign red_wide   = WideW'(red_upd);

  always_comb begin
    res.blue_total  = blue_wide[TOTAL_W-1:0];
    res.green_total = green_wide[TOTAL_W-1:0];
    res.red_total   = red_wide[TOTAL_W-1:0];
    if (blue_upd > green_upd && blue_upd > red_upd) begin
      res.verdict = VERDICT_BLUE;
    end else if (green_upd > blue_upd && green_upd > red_upd) begin
      res.verdict = VERDICT_GREEN;
    end else begin
      res.verdict = VERDICT_RED;
    end
  end

  // counter update, cleared after a frame closes
  always_comb begin
    blue_acc_nxt  = blue_acc_r;
    green_acc_nxt = green_acc_r;
    red_acc_nxt   = red_acc_r;
    if (cmd_pop) begin
      if (cmd.last) begin
        blue_acc_nxt  = '0;
        green_acc_nxt = '0;
        red_acc_nxt   = '0;
      end else begin
        blue_acc_nxt  = blue_upd;
        green_acc_nxt = green_upd;
        red_acc_nxt   = red_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_acc_r  <= '0;
      green_acc_r <= '0;
      red_acc_r   <= '0;
    end else begin
      blue_acc_r  <= blue_acc_nxt;
      green_acc_r <= green_acc_nxt;
      red_acc_r   <= red_acc_nxt;
    end
  end

  a_clear_after_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.last) |=> (blue_acc_r == '0 && green_acc_r == '0 && red_acc_r == '0))
    else $error("counters not cleared after frame end");

  a_hold_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_pop |=> ($stable(blue_acc_r) && $stable(green_acc_r) && $stable(red_acc_r)))
    else $error("counters changed without a command");

  a_single_vote : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && !cmd.last) |=> ($countones({blue_acc_r != $past(blue_acc_r),
      green_acc_r != $past(green_acc_r), red_acc_r != $past(red_acc_r)}) <= 1))
    else $error("more than one counter moved on one pixel");

endmodule

`default_nettype wire

FILE: rtl/dominant_colour_pixel_vote.sv
`timescale 1ns / 1ps
`default_nettype none

// Dominant colour vote over a pixel stream. One pixel item is taken per clock
// while in_full is low. The front end tests the pixel (blue, green, red in
// that order, each against the level threshold and 2a > 3b against the other
// two) and the column band, and writes a vote command into a two-entry queue;
// the back end applies one command per clock to three saturating counters
// unless a closing command waits for room in the result queue. On a
// frame_end pixel the back end forms the totals and verdict from the counters
// including that pixel, writes them into a two-entry result queue and clears
// the counters. A closing pixel passes the command queue and its result the
// result queue before the result shows on the result ports. in_full rises
// only when the result queue is full and the command queue has filled behind
// it; configuration writes complete in the cycle they are presented.
module dominant_colour_pixel_vote import dcpv_pkg::*; #(
  parameter int COUNT_WIDTH  = 24,
  parameter int COLUMN_WIDTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel input
  input  wire logic                  in_push,
  input  wire pixel_t                in_data,
  output logic                       in_full,
  // result output
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output result_t                    out_data,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  vote_t   front_cmd;
  vote_t   back_cmd;
  logic    cmd_push;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;
  result_t res;

  assign cmd_push = in_push && !in_full;

  // pixel classification and configuration
  dcpv_front #(
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (in_data),
    .vote_cmd  (front_cmd)
  );

  // command queue between front and back
  dcpv_queue #(
    .WIDTH ($bits(vote_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd),
    .empty     (cmd_empty)
  );

  // counters and result forming
  dcpv_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  dcpv_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop && !out_empty),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dcpv_pkg::*;

  localparam int COUNT_W  = 24;
  localparam int COLUMN_W = 12;
  localparam longint COUNT_MAX = (longint'(1) << COUNT_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  pixel_t in_data = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // settings as the block should hold them
  logic [LEVEL_W-1:0] level_floor;
  logic [COLUMN_W-1:0] band_lo;
  logic [COLUMN_W-1:0] band_hi;
  logic [BONUS_W-1:0] bonus_step;

  // vote counters of the current frame
  logic [TOTAL_W-1:0] blue_votes;
  logic [TOTAL_W-1:0] green_votes;
  logic [TOTAL_W-1:0] red_votes;

  result_t totals_due[$];
  int mismatch_count = 0;

  // stimulus control shared between tests and the driver processes
  bit sender_eager = 1'b0;
  bit pop_eager = 1'b0;
  int hold_request = 0;

  dominant_colour_pixel_vote #(
    .COUNT_WIDTH(COUNT_W),
    .COLUMN_WIDTH(COLUMN_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_data(in_data),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // channel a wins over b and c when above the floor and 2a > 3b, 2a > 3c
  function automatic bit beats(int a, int b, int c);
    return (2 * a > 3 * b) && (2 * a > 3 * c) && (a > int'(level_floor));
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] acc, int step);
    longint sum;
    sum = longint'(acc) + step;
    return (sum > COUNT_MAX) ? TOTAL_W'(COUNT_MAX) : TOTAL_W'(sum);
  endfunction

  // count one pixel; on the closing pixel form the frame totals and clear
  function automatic bit tally_pixel(input pixel_t px, output result_t res);
    int b, g, r, step;
    b = px.blue_level;
    g = px.green_level;
    r = px.red_level;
    step = 1;
    res = '0;
    if (px.column_index > band_lo && px.column_index < band_hi) step += bonus_step;
    if (beats(b, g, r)) blue_votes = sat_inc(blue_votes, step);
    else if (beats(g, b, r)) green_votes = sat_inc(green_votes, step);
    else if (beats(r, b, g)) red_votes = sat_inc(red_votes, step);
    if (!px.frame_end) return 1'b0;
    if (blue_votes > green_votes && blue_votes > red_votes) res.verdict = VERDICT_BLUE;
    else if (green_votes > blue_votes && green_votes > red_votes) res.verdict = VERDICT_GREEN;
    else res.verdict = VERDICT_RED;
    res.blue_total = blue_votes;
    res.green_total = green_votes;
    res.red_total = red_votes;
    blue_votes = '0;
    green_votes = '0;
    red_votes = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", what, want, seen);
    end
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      level_floor = MIN_LEVEL_RST;
      band_lo = BAND_START_RST;
      band_hi = BAND_END_RST;
      bonus_step = BAND_BONUS_RST;
      blue_votes = '0;
      green_votes = '0;
      red_votes = '0;
    end else begin
      if (out_pop && !out_empty) begin
        if (totals_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result with nothing pending: %p", out_data);
        end else begin
          want = totals_due.pop_front();
          check_field("verdict", want.verdict, out_data.verdict);
          check_field("blue_total", want.blue_total, out_data.blue_total);
          check_field("green_total", want.green_total, out_data.green_total);
          check_field("red_total", want.red_total, out_data.red_total);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_LEVEL:  level_floor = cfg_data[LEVEL_W-1:0];
          REG_BAND_START: band_lo = cfg_data[COLUMN_W-1:0];
          REG_BAND_END:   band_hi = cfg_data[COLUMN_W-1:0];
          REG_BAND_BONUS: bonus_step = cfg_data[BONUS_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (tally_pixel(in_data, want)) totals_due.push_back(want);
      end
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
        if (!pop_eager) stall_left = pick_gap();
      end
    end
  end

  task automatic send_pixel(pixel_t px);
    int gap;
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full);
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_levels(int b, int g, int r, int col, bit last);
    pixel_t px;
    px.blue_level = LEVEL_W'(b);
    px.green_level = LEVEL_W'(g);
    px.red_level = LEVEL_W'(r);
    px.column_index = COLUMN_W'(col);
    px.frame_end = last;
    send_pixel(px);
  endtask

  // stop sending and let every pending frame result come out
  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits get random junk that the block must drop
  task automatic apply_settings(int lvl, int lo, int hi, int bonus);
    write_reg(REG_MIN_LEVEL, {4'($urandom), 8'(lvl)});
    write_reg(REG_BAND_START, 12'(lo));
    write_reg(REG_BAND_END, 12'(hi));
    write_reg(REG_BAND_BONUS, {8'($urandom), 4'(bonus)});
  endtask

  function automatic pixel_t random_pixel(bit last);
    pixel_t px;
    int lv[3];
    int top, lim, c, r;
    r = $urandom_range(99);
    c = $urandom_range(2);
    if (r < 75) begin
      // one clearly leading channel, sometimes right at the level floor
      top = $urandom_range(255);
      if (r >= 60) begin
        top = int'(level_floor) + $urandom_range(2) - 1;
        if (top < 0) top = 0;
        if (top > 255) top = 255;
      end
      lim = (2 * top) / 3;
      for (int i = 0; i < 3; i++) lv[i] = $urandom_range(lim);
      lv[c] = top;
    end else begin
      for (int i = 0; i < 3; i++) lv[i] = $urandom_range(255);
    end
    px.blue_level = LEVEL_W'(lv[0]);
    px.green_level = LEVEL_W'(lv[1]);
    px.red_level = LEVEL_W'(lv[2]);
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(3))
        0: px.column_index = band_lo;
        1: px.column_index = band_lo + 1'b1;
        2: px.column_index = band_hi - 1'b1;
        default: px.column_index = band_hi;
      endcase
    end else begin
      px.column_index = COLUMN_W'($urandom_range(4095));
    end
    px.frame_end = last;
    return px;
  endfunction

  // settings after reset: vote order, band edges, level floor, 2a > 3b edge
  task automatic test_reset_settings();
    send_levels(255, 0, 0, 200, 0);
    send_levels(0, 255, 0, 128, 0);
    send_levels(0, 0, 255, 512, 0);
    send_levels(0, 0, 255, 129, 0);
    send_levels(0, 255, 0, 511, 0);
    send_levels(125, 0, 0, 0, 0);
    send_levels(126, 84, 0, 4095, 0);
    send_levels(126, 83, 83, 300, 0);
    send_levels(200, 200, 200, 300, 1);
    // tie between green and red goes to red
    send_levels(0, 150, 0, 0, 0);
    send_levels(0, 0, 150, 0, 1);
    send_levels(0, 0, 0, 0, 1);
    send_levels(100, 255, 100, 4095, 1);
    wait_idle();
  endtask

  // zero floor with full band, empty band, top floor, zero bonus
  task automatic test_setting_extremes();
    apply_settings(0, 0, 4095, 15);
    send_levels(1, 0, 0, 1, 0);
    send_levels(0, 1, 0, 4094, 0);
    send_levels(0, 0, 1, 0, 0);
    send_levels(0, 0, 1, 4095, 1);
    wait_idle();
    apply_settings(200, 100, 101, 15);
    send_levels(255, 0, 0, 100, 0);
    send_levels(0, 255, 0, 101, 1);
    wait_idle();
    apply_settings(255, 4095, 0, 0);
    send_levels(255, 0, 0, 2000, 0);
    send_levels(0, 0, 255, 2000, 1);
    wait_idle();
    apply_settings(10, 5, 20, 0);
    send_levels(50, 0, 0, 10, 1);
    wait_idle();
  endtask

  // random frames under the reset settings, a wide-open setting and random ones
  task automatic test_random_frames();
    int frame_len, lo;
    for (int phase = 0; phase < 6; phase++) begin
      lo = $urandom_range(3000);
      case (phase)
        0: apply_settings(MIN_LEVEL_RST, BAND_START_RST, BAND_END_RST, BAND_BONUS_RST);
        1: apply_settings(0, 0, 4095, 15);
        2: apply_settings($urandom_range(255), $urandom_range(4095),
                          $urandom_range(4095), $urandom_range(15));
        default: apply_settings($urandom_range(200), lo, lo + $urandom_range(1095),
                                $urandom_range(15));
      endcase
      sender_eager = ($urandom_range(3) == 0);
      pop_eager = ($urandom_range(3) == 0);
      for (int sent = 0; sent < 70; sent += frame_len) begin
        frame_len = ($urandom_range(99) < 70) ? $urandom_range(6, 1) : $urandom_range(40, 7);
        for (int i = 0; i < frame_len; i++)
          send_pixel(random_pixel(i == frame_len - 1));
      end
      wait_idle();
    end
    sender_eager = 1'b0;
    pop_eager = 1'b0;
  endtask

  // result side held off while single-pixel frames keep coming
  task automatic test_result_backpressure();
    hold_request = 80;
    sender_eager = 1'b1;
    repeat (24) send_pixel(random_pixel(1'b1));
    sender_eager = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_settings();
    test_setting_extremes();
    test_random_frames();
    test_result_backpressure();
    repeat (10) @(posedge clk);
    if (totals_due.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
